// ----- rtl/vn_pkg.sv -----
// vn_pkg: shared constants for the vec3_normalize block
// no dependencies; imported by every module of the block

package vn_pkg;

    // width of the unit and magnitude result fields
    localparam int OUT_WIDTH   = 16;

    // depth of the queue between front and back, and its pointer width
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = 2;

endpackage

// ----- rtl/vn_front.sv -----
// vn_front: accepts vectors, splits sign and magnitude, sums the squares
// and flags the zero vector; depends on vn_pkg

module vn_front
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [COMPONENT_WIDTH-1:0]             x_in,
    input  logic [COMPONENT_WIDTH-1:0]             y_in,
    input  logic [COMPONENT_WIDTH-1:0]             z_in,
    output logic                                   f_push,
    input  logic                                   f_full,
    output logic [2:0][COMPONENT_WIDTH-1:0]        f_mag,
    output logic [2:0]                             f_neg,
    output logic [2*COMPONENT_WIDTH-1:0]           f_sum,
    output logic                                   f_zero
);

    localparam int CW = COMPONENT_WIDTH;

    logic                      en;
    logic [2:0][CW-1:0]        comp;
    logic [2:0][CW-1:0]        mag_next;
    logic [2:0][2*CW-1:0]      sq_next;

    logic                      a_valid_reg;
    logic [2:0][CW-1:0]        a_mag_reg;
    logic [2:0]                a_neg_reg;
    logic [2:0][2*CW-1:0]      a_sq_reg;

    logic                      b_valid_reg;
    logic [2:0][CW-1:0]        b_mag_reg;
    logic [2:0]                b_neg_reg;
    logic [2*CW-1:0]           b_sum_reg;
    logic                      b_zero_reg;

    // whole front advances unless the last stage is blocked by the queue
    assign en     = !(b_valid_reg && f_full);
    assign full   = !en;
    assign f_push = b_valid_reg && !f_full;

    assign comp[0] = x_in;
    assign comp[1] = y_in;
    assign comp[2] = z_in;

    // magnitude and square of each component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = comp[i][CW-1] ? (~comp[i] + CW'(1)) : comp[i];
            sq_next[i]  = (2*CW)'(mag_next[i]) * (2*CW)'(mag_next[i]);
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= push;
            b_valid_reg <= a_valid_reg;
        end
    end

    // stage payload: squares, then their sum and the zero class
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= mag_next[i];
                a_neg_reg[i] <= comp[i][CW-1];
                a_sq_reg[i]  <= sq_next[i];
            end
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_sum_reg  <= a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
            b_zero_reg <= (a_mag_reg == '0);
        end
    end

    assign f_mag  = b_mag_reg;
    assign f_neg  = b_neg_reg;
    assign f_sum  = b_sum_reg;
    assign f_zero = b_zero_reg;

    // zero class agrees with the sum of squares
    a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_zero_reg == (b_sum_reg == '0)))
        else $error("zero flag disagrees with sum of squares");

endmodule

// ----- rtl/vn_queue.sv -----
// vn_queue: short register queue between front and back
// depends on vn_pkg for its depth

module vn_queue
    import vn_pkg::*;
#(
    parameter int DATA_WIDTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    output logic                  q_full,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd,
    output logic                  q_empty,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0]  mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_WIDTH-1:0]  wr_ptr_reg;
    logic [QPTR_WIDTH-1:0]  rd_ptr_reg;
    logic [QPTR_WIDTH:0]    count_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign q_full  = (count_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_WIDTH'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_WIDTH'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (QPTR_WIDTH+1)'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - (QPTR_WIDTH+1)'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // pointer distance matches the count
    a_count_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_WIDTH-1:0])
        else $error("queue pointers disagree with count");

    // front never offers a transaction into a full queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> !q_full)
        else $error("write into full queue");

endmodule

// ----- rtl/vn_back.sv -----
// vn_back: pipelined square root then three pipelined dividers, with an
// output register; depends on vn_pkg

module vn_back
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH    = 16,
    parameter int UNIT_FRACTION_BITS = 14
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    output logic                             q_rd,
    input  logic [2:0][COMPONENT_WIDTH-1:0]  q_mag,
    input  logic [2:0]                       q_neg,
    input  logic [2*COMPONENT_WIDTH-1:0]     q_sum,
    input  logic                             q_zero,
    output logic                             empty,
    input  logic                             pop,
    output logic [OUT_WIDTH-1:0]             x_unit,
    output logic [OUT_WIDTH-1:0]             y_unit,
    output logic [OUT_WIDTH-1:0]             z_unit,
    output logic [OUT_WIDTH-1:0]             magnitude,
    output logic                             was_zero
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int FB = UNIT_FRACTION_BITS;
    localparam int DS = FB + 1;

    logic en;

    // square root stages, index 0 loaded from the queue
    logic                  sq_valid_reg [0:CW];
    logic [2*CW-1:0]       sq_n_reg     [0:CW];
    logic [CW+1:0]         sq_rem_reg   [0:CW];
    logic [CW-1:0]         sq_root_reg  [0:CW];
    logic [2:0][CW-1:0]    sq_mag_reg   [0:CW];
    logic [2:0]            sq_neg_reg   [0:CW];
    logic                  sq_zero_reg  [0:CW];

    // divider stages, index k holds k quotient bits
    logic                  dv_valid_reg [1:DS];
    logic [CW-1:0]         dv_len_reg   [1:DS];
    logic [2:0][CW-1:0]    dv_rem_reg   [1:DS];
    logic [2:0][FB:0]      dv_q_reg     [1:DS];
    logic [2:0]            dv_neg_reg   [1:DS];
    logic                  dv_zero_reg  [1:DS];

    // output register
    logic                  out_valid_reg;
    logic [2:0][OUT_WIDTH-1:0] out_unit_reg;
    logic [OUT_WIDTH-1:0]  out_mag_reg;
    logic                  out_zero_reg;
    logic [2:0][OUT_WIDTH-1:0] unit_next;
    logic [31:0]           len_wide;

    // the back stalls as one piece while a result waits unread
    assign en   = !out_valid_reg || pop;
    assign q_rd = en && !q_empty;

    // stage 0 load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (en)
            sq_valid_reg[0] <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_n_reg[0]    <= q_sum;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_mag_reg[0]  <= q_mag;
            sq_neg_reg[0]  <= q_neg;
            sq_zero_reg[0] <= q_zero;
        end
    end

    // one root bit per stage, restoring digit recurrence
    for (genvar i = 0; i < CW; i++)
    begin : g_sqrt
        logic [CW+2:0] sh;
        logic [CW+2:0] trial;
        logic          ge;
        logic [CW+2:0] rem_next;

        assign sh       = {sq_rem_reg[i][CW:0], sq_n_reg[i][2*CW-1 -: 2]};
        assign trial    = {1'b0, sq_root_reg[i], 2'b01};
        assign ge       = (sh >= trial);
        assign rem_next = ge ? (sh - trial) : sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[i+1] <= 1'b0;
            else if (en)
                sq_valid_reg[i+1] <= sq_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[i+1]    <= {sq_n_reg[i][2*CW-3:0], 2'b00};
                sq_rem_reg[i+1]  <= rem_next[CW+1:0];
                sq_root_reg[i+1] <= {sq_root_reg[i][CW-2:0], ge};
                sq_mag_reg[i+1]  <= sq_mag_reg[i];
                sq_neg_reg[i+1]  <= sq_neg_reg[i];
                sq_zero_reg[i+1] <= sq_zero_reg[i];
            end
        end
    end

    // one quotient bit per stage for each of the three lanes
    for (genvar k = 0; k < DS; k++)
    begin : g_div
        logic               in_valid;
        logic [CW-1:0]      in_len;
        logic [2:0][CW-1:0] in_rem;
        logic [2:0][FB:0]   in_q;
        logic [2:0]         in_neg;
        logic               in_zero;

        if (k == 0)
        begin : g_first
            assign in_valid = sq_valid_reg[CW];
            assign in_len   = sq_root_reg[CW];
            assign in_rem   = sq_mag_reg[CW];
            assign in_q     = '0;
            assign in_neg   = sq_neg_reg[CW];
            assign in_zero  = sq_zero_reg[CW];
        end
        else
        begin : g_rest
            assign in_valid = dv_valid_reg[k];
            assign in_len   = dv_len_reg[k];
            assign in_rem   = dv_rem_reg[k];
            assign in_q     = dv_q_reg[k];
            assign in_neg   = dv_neg_reg[k];
            assign in_zero  = dv_zero_reg[k];
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [CW:0] t;
            logic        ge;
            logic [CW:0] rem_next;

            // first step compares the magnitude itself, later ones shift
            if (k == 0)
            begin : g_nosh
                assign t = {1'b0, in_rem[l]};
            end
            else
            begin : g_sh
                assign t = {in_rem[l], 1'b0};
            end
            assign ge       = (t >= {1'b0, in_len});
            assign rem_next = ge ? (t - {1'b0, in_len}) : t;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[k+1][l] <= rem_next[CW-1:0];
                    dv_q_reg[k+1][l]   <= {in_q[l][FB-1:0], ge};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= in_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[k+1]  <= in_len;
                dv_neg_reg[k+1]  <= in_neg;
                dv_zero_reg[k+1] <= in_zero;
            end
        end
    end

    // zero the result for a zero vector, else apply sign and cut to the result field width
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dv_zero_reg[DS])
                unit_next[l] = '0;
            else if (dv_neg_reg[DS][l])
                unit_next[l] = OUT_WIDTH'(32'd0 - 32'(dv_q_reg[DS][l]));
            else
                unit_next[l] = OUT_WIDTH'(32'(dv_q_reg[DS][l]));
        end
    end

    assign len_wide = 32'(dv_len_reg[DS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[DS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_unit_reg <= unit_next;
            out_mag_reg  <= len_wide[OUT_WIDTH-1:0];
            out_zero_reg <= dv_zero_reg[DS];
        end
    end

    assign empty     = !out_valid_reg;
    assign x_unit    = out_unit_reg[0];
    assign y_unit    = out_unit_reg[1];
    assign z_unit    = out_unit_reg[2];
    assign magnitude = out_mag_reg;
    assign was_zero  = out_zero_reg;

    // a zero vector has zero length at the end of the root
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[CW] |-> (sq_zero_reg[CW] == (sq_root_reg[CW] == '0)))
        else $error("root disagrees with zero class");

endmodule

// ----- rtl/vec3_normalize.sv -----
// vec3_normalize: top level, front, queue and back of the vector normalizer
// depends on vn_pkg, vn_front, vn_queue and vn_back
//
//  channel   direction  handshake         payload
//  input     in         push / full       x_in, y_in, z_in
//  result    out        empty / pop       x_unit, y_unit, z_unit, magnitude, was_zero
//
// one transaction per clock is sustained while results are popped
// a result reaches the ports through the front stages, the queue, the root load
// stage, COMPONENT_WIDTH root stages, UNIT_FRACTION_BITS+1 divider stages and
// the output register
// the root pipeline and three divider lanes each give one bit per stage
// a waiting result stalls the back; the front keeps filling the 4-entry queue
// reset clears only valid bits, queue pointers and the queue fill count

module vec3_normalize
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH    = 16,
    parameter int UNIT_FRACTION_BITS = 14
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [COMPONENT_WIDTH-1:0]  x_in,
    input  logic [COMPONENT_WIDTH-1:0]  y_in,
    input  logic [COMPONENT_WIDTH-1:0]  z_in,
    output logic                        empty,
    input  logic                        pop,
    output logic [OUT_WIDTH-1:0]        x_unit,
    output logic [OUT_WIDTH-1:0]        y_unit,
    output logic [OUT_WIDTH-1:0]        z_unit,
    output logic [OUT_WIDTH-1:0]        magnitude,
    output logic                        was_zero
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int DW = 3*CW + 3 + 2*CW + 1;

    logic                  f_push;
    logic                  f_full;
    logic [2:0][CW-1:0]    f_mag;
    logic [2:0]            f_neg;
    logic [2*CW-1:0]       f_sum;
    logic                  f_zero;
    logic                  q_rd;
    logic                  q_empty;
    logic [DW-1:0]         q_data;
    logic [2:0][CW-1:0]    q_mag;
    logic [2:0]            q_neg;
    logic [2*CW-1:0]       q_sum;
    logic                  q_zero;

    // front: sign split, squares, sum, zero class
    vn_front #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .x_in   (x_in),
        .y_in   (y_in),
        .z_in   (z_in),
        .f_push (f_push),
        .f_full (f_full),
        .f_mag  (f_mag),
        .f_neg  (f_neg),
        .f_sum  (f_sum),
        .f_zero (f_zero)
    );

    // decoupling queue
    vn_queue #(
        .DATA_WIDTH (DW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .q_full  (f_full),
        .wr_data ({f_mag, f_neg, f_sum, f_zero}),
        .rd      (q_rd),
        .q_empty (q_empty),
        .rd_data (q_data)
    );

    assign {q_mag, q_neg, q_sum, q_zero} = q_data;

    // back: root, division, output register
    vn_back #(
        .COMPONENT_WIDTH    (COMPONENT_WIDTH),
        .UNIT_FRACTION_BITS (UNIT_FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .q_mag     (q_mag),
        .q_neg     (q_neg),
        .q_sum     (q_sum),
        .q_zero    (q_zero),
        .empty     (empty),
        .pop       (pop),
        .x_unit    (x_unit),
        .y_unit    (y_unit),
        .z_unit    (z_unit),
        .magnitude (magnitude),
        .was_zero  (was_zero)
    );

    // zero results carry zero components
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && was_zero) |-> (x_unit == '0 && y_unit == '0 && z_unit == '0))
        else $error("zero vector gave nonzero components");

endmodule
